// ----- rtl/crt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg: calendar clock shared types and tables
// Word formats, event levels and the calendar lookups used by the update
// logic and the top level.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam logic [2:0] LVL_HALF   = 3'd0;
  localparam logic [2:0] LVL_SECOND = 3'd1;
  localparam logic [2:0] LVL_MINUTE = 3'd2;
  localparam logic [2:0] LVL_HOUR   = 3'd3;
  localparam logic [2:0] LVL_DAY    = 3'd4;
  localparam logic [2:0] LVL_WRITE  = 3'd5;

  localparam logic [6:0]  YEAR_MAX    = 7'd99;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [4:0]  HOUR_MAX    = 5'd23;
  localparam logic [5:0]  MINSEC_MAX  = 6'd59;
  localparam logic [6:0]  YEAR_RST    = 7'd18;
  localparam logic [2:0]  WEEKDAY_RST = 3'd1;
  localparam logic [15:0] ZONE_RST    = 16'h0800;

  typedef struct packed {
    logic        mode;
    logic [7:0]  new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;
    logic [15:0] new_zone;
  } crt_in_t;

  typedef struct packed {
    logic [2:0]  event_level;
    logic [6:0]  year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [2:0]  weekday_now;
    logic [15:0] zone_now;
  } crt_out_t;

  typedef struct packed {
    logic        half_phase;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [15:0] zone;
  } crt_time_t;

  // bits 2..0: weekday of Jan 1, bit 3: leap year
  localparam logic [3:0] JAN1_TAB [100] = '{
    4'he, 4'h1, 4'h2, 4'h3, 4'hc, 4'h6, 4'h0, 4'h1, 4'ha, 4'h4,
    4'h5, 4'h6, 4'h8, 4'h2, 4'h3, 4'h4, 4'hd, 4'h0, 4'h1, 4'h2,
    4'hb, 4'h5, 4'h6, 4'h0, 4'h9, 4'h3, 4'h4, 4'h5, 4'he, 4'h1,
    4'h2, 4'h3, 4'hc, 4'h6, 4'h0, 4'h1, 4'ha, 4'h4, 4'h5, 4'h6,
    4'h8, 4'h2, 4'h3, 4'h4, 4'hd, 4'h0, 4'h1, 4'h2, 4'hb, 4'h5,
    4'h6, 4'h0, 4'h9, 4'h3, 4'h4, 4'h5, 4'he, 4'h1, 4'h2, 4'h3,
    4'hc, 4'h6, 4'h0, 4'h1, 4'ha, 4'h4, 4'h5, 4'h6, 4'h8, 4'h2,
    4'h3, 4'h4, 4'hd, 4'h0, 4'h1, 4'h2, 4'hb, 4'h5, 4'h6, 4'h0,
    4'h9, 4'h3, 4'h4, 4'h5, 4'he, 4'h1, 4'h2, 4'h3, 4'hc, 4'h6,
    4'h0, 4'h1, 4'ha, 4'h4, 4'h5, 4'h6, 4'h8, 4'h2, 4'h3, 4'h4
  };

  // days before the 1st of each month, modulo 7, non-leap year
  localparam logic [2:0] DAYS_BEFORE_MOD7 [13] = '{
    3'd0, 3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5
  };

  localparam logic [4:0] MONTH_LEN [13] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    return (m > MONTH_MAX) ? MONTH_MAX : m;
  endfunction

  function automatic logic [3:0] jan1_entry(input logic [6:0] y);
    return (y > YEAR_MAX) ? 4'h0 : JAN1_TAB[y];
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one final correction
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [3:0] a;
    logic [2:0] b;
    a = {1'b0, v[5:3]} + {1'b0, v[2:0]};
    b = a[2:0] + {2'b00, a[3]};
    return (b == 3'd7) ? 3'd0 : b;
  endfunction

  function automatic logic [2:0] weekday_of(input logic [6:0] y, input logic [3:0] m,
                                            input logic [4:0] d);
    logic [3:0] e;
    logic [3:0] mm;
    logic [5:0] n;
    e  = jan1_entry(y);
    mm = clamp_month(m);
    n  = {3'b000, DAYS_BEFORE_MOD7[mm]} + {1'b0, d} + {3'b000, e[2:0]} + 6'd6
         + {5'd0, (e[3] && (mm > 4'd2))};
    return mod7(n);
  endfunction

  function automatic logic [4:0] days_in(input logic [6:0] y, input logic [3:0] m);
    logic [3:0] mm;
    mm = clamp_month(m);
    return (mm == 4'd2 && y[1:0] == 2'b00) ? 5'd29 : MONTH_LEN[mm];
  endfunction

endpackage

// ----- rtl/calendar_rtc_tick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_rtc_tick: calendar real-time clock, years 2000-2099
// Half-second ticks and time writes in, one time report word out per command.
// ----------------------------------------------------------------------------
// Each command word gives exactly one report word, in order. A command is
// taken into an input register, applied to the time registers by update
// logic (second through year rollover, leap rule, weekday lookup) and the
// report is held in an output register, so the block accepts one command
// per clock while reports are taken. A stalled report blocks at most one
// further command in the input register. Reset time is 2018-01-01 00:00:00,
// Monday, zone 0x0800; a write with day 0 or month, hour, minute, second or
// year out of range loads 2018-01-01 00:00:00 with zone 0.
module calendar_rtc_tick (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  crt_pkg::crt_in_t  cmd,
  output logic              rpt_valid,
  input  logic              rpt_ready,
  output crt_pkg::crt_out_t rpt
);
  import crt_pkg::*;

  logic      advance;
  logic      held_valid;
  crt_in_t   held;
  crt_time_t time_q;
  crt_time_t time_next;
  crt_out_t  rpt_next;
  logic      consume;

  assign advance = !rpt_valid || rpt_ready;
  assign consume = held_valid && advance;

  crt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  crt_update u_update (
    .cur       (time_q),
    .cmd       (held),
    .time_next (time_next),
    .rpt_next  (rpt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_q.half_phase <= 1'b0;
      time_q.year       <= YEAR_RST;
      time_q.month      <= 4'd1;
      time_q.day        <= 5'd1;
      time_q.hour       <= 5'd0;
      time_q.minute     <= 6'd0;
      time_q.second     <= 6'd0;
      time_q.weekday    <= WEEKDAY_RST;
      time_q.zone       <= ZONE_RST;
    end else if (consume) begin
      time_q <= time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (consume) begin
      rpt_valid <= 1'b1;
    end else if (rpt_ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      rpt <= rpt_next;
    end
  end

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (time_q.second <= MINSEC_MAX) && (time_q.minute <= MINSEC_MAX) &&
    (time_q.hour <= HOUR_MAX))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (time_q.month != 4'd0) && (time_q.month <= MONTH_MAX) &&
    (time_q.day != 5'd0) && (time_q.year <= YEAR_MAX) && (time_q.weekday != 3'd7))
    else $error("date out of range");

  a_half_tick: assert property (@(posedge clk) disable iff (rst)
    (consume && !held.mode && !time_q.half_phase) |=>
    (rpt_valid && rpt.event_level == LVL_HALF && time_q.half_phase))
    else $error("half-second tick not reported as half level");

  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !advance) |-> !cmd_ready)
    else $error("command taken while input register is stalled");

  a_write_level: assert property (@(posedge clk) disable iff (rst)
    (consume && held.mode) |=> (rpt_valid && rpt.event_level == LVL_WRITE))
    else $error("write not reported as write level");

endmodule

// ----- rtl/crt_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_in_reg: command input register
// Holds one command word; refills in the same cycle the held word moves on.
// ----------------------------------------------------------------------------
module crt_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  crt_pkg::crt_in_t cmd,
  input  logic            advance,
  output logic            held_valid,
  output crt_pkg::crt_in_t held
);
  import crt_pkg::*;

  assign cmd_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      held <= cmd;
    end
  end

endmodule

// ----- rtl/crt_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_update: calendar next-state logic
// Applies one tick or write to the current time and forms the report word.
// ----------------------------------------------------------------------------
module crt_update (
  input  crt_pkg::crt_time_t cur,
  input  crt_pkg::crt_in_t   cmd,
  output crt_pkg::crt_time_t time_next,
  output crt_pkg::crt_out_t  rpt_next
);
  import crt_pkg::*;

  logic       bad;
  logic [5:0] sec_inc;
  logic [5:0] min_inc;
  logic [4:0] hour_inc;
  logic [5:0] day_inc;
  logic [3:0] mon_inc;
  logic [6:0] year_inc;
  logic [2:0] level;

  assign sec_inc  = cur.second + 6'd1;
  assign min_inc  = cur.minute + 6'd1;
  assign hour_inc = cur.hour + 5'd1;
  assign day_inc  = {1'b0, cur.day} + 6'd1;
  assign mon_inc  = cur.month + 4'd1;
  assign year_inc = cur.year + 7'd1;

  assign bad = (cmd.new_month == 4'd0) || (cmd.new_month > MONTH_MAX) ||
               (cmd.new_day == 5'd0) || (cmd.new_hour > HOUR_MAX) ||
               (cmd.new_minute > MINSEC_MAX) || (cmd.new_second > MINSEC_MAX) ||
               (cmd.new_year > {1'b0, YEAR_MAX});

  always_comb begin
    time_next = cur;
    level     = LVL_HALF;
    if (cmd.mode) begin
      level = LVL_WRITE;
      if (bad) begin
        time_next.year   = YEAR_RST;
        time_next.month  = 4'd1;
        time_next.day    = 5'd1;
        time_next.hour   = 5'd0;
        time_next.minute = 6'd0;
        time_next.second = 6'd0;
        time_next.zone   = 16'h0000;
      end else begin
        time_next.year   = cmd.new_year[6:0];
        time_next.month  = cmd.new_month;
        time_next.day    = cmd.new_day;
        time_next.hour   = cmd.new_hour;
        time_next.minute = cmd.new_minute;
        time_next.second = cmd.new_second;
        time_next.zone   = cmd.new_zone;
      end
      time_next.weekday = weekday_of(time_next.year, time_next.month, time_next.day);
    end else if (!cur.half_phase) begin
      time_next.half_phase = 1'b1;
    end else begin
      time_next.half_phase = 1'b0;
      level                = LVL_SECOND;
      time_next.second     = sec_inc;
      if (sec_inc > MINSEC_MAX) begin
        level            = LVL_MINUTE;
        time_next.second = 6'd0;
        time_next.minute = min_inc;
        if (min_inc > MINSEC_MAX) begin
          level            = LVL_HOUR;
          time_next.minute = 6'd0;
          time_next.hour   = hour_inc;
          if (hour_inc > HOUR_MAX) begin
            level          = LVL_DAY;
            time_next.hour = 5'd0;
            time_next.day  = day_inc[4:0];
            if (day_inc > {1'b0, days_in(cur.year, cur.month)}) begin
              time_next.day   = 5'd1;
              time_next.month = mon_inc;
              if (mon_inc > MONTH_MAX) begin
                time_next.month = 4'd1;
                time_next.year  = (year_inc > YEAR_MAX) ? 7'd0 : year_inc;
              end
            end
            time_next.weekday = weekday_of(time_next.year, time_next.month,
                                           time_next.day);
          end
        end
      end
    end
  end

  always_comb begin
    rpt_next.event_level = level;
    rpt_next.year_now    = time_next.year;
    rpt_next.month_now   = time_next.month;
    rpt_next.day_now     = time_next.day;
    rpt_next.hour_now    = time_next.hour;
    rpt_next.minute_now  = time_next.minute;
    rpt_next.second_now  = time_next.second;
    rpt_next.weekday_now = time_next.weekday;
    rpt_next.zone_now    = time_next.zone;
  end

endmodule
